[hw/rtl/deq_pkg.sv]
`timescale 1ns / 1ps

package deq_pkg;

    localparam int DEPTH   = 16;
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;

    localparam logic signed [DATA_W-1:0] EMPTY_WORD = '1;

    typedef enum logic [1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_BACK  = 2'd1,
        KIND_POP_FRONT  = 2'd2,
        KIND_POP_BACK   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // One access to the entry storage per cycle.
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [PTR_W-1:0]  addr;
        logic [DATA_W-1:0] wr_data;
    } ram_req_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == '0)
            r = PTR_W'(DEPTH - 1);
        else
            r = p - PTR_W'(1);
        return r;
    endfunction

endpackage

[hw/rtl/deq_ram.sv]
`timescale 1ns / 1ps

// Single-port entry storage with registered read data.
module deq_ram
    import deq_pkg::*;
(
    input  logic              clk,
    input  ram_req_t          req,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/double_ended_queue_core.sv]
`timescale 1ns / 1ps
// Latency: a result is offered in the cycle after its command transaction is accepted.
// Throughput: one command per cycle while cmd_stall is low; the single storage port is used at most once per command.
// A command is held off only while a finished result waits on a stalled result channel.
// Reset (rst_n low, asynchronous) empties the queue: head, tail, fill and result valid clear.
// The entry storage is not cleared; only entries written by inserts are ever read.
module double_ended_queue_core
    import deq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    output logic                      cmd_stall,
    input  logic [1:0]                kind,
    input  logic signed [DATA_W-1:0]  value,
    output logic                      res_valid,
    input  logic                      res_stall,
    output logic signed [DATA_W-1:0]  value_res,
    output logic [1:0]                status,
    output logic [COUNT_W-1:0]        count
);

    // Queue pointers. The head indexes the front entry, the tail indexes the
    // slot just past the back entry; both wrap around the ring.
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;

    // Result stage. The removed word itself sits in the storage read register
    // and is only selected onto value_res here.
    logic              res_valid_reg, res_valid_next;
    status_t           status_reg, status_next;
    logic              pop_ok_reg, pop_ok_next;
    logic [CNT_W-1:0]  fill_out_reg;

    logic              accept;
    logic              full;
    logic              empty;
    kind_t             op;
    ram_req_t          ram_req;
    logic [DATA_W-1:0] rd_data;

    // A new command may enter whenever the result stage is empty or is being
    // drained in this same cycle.
    assign cmd_stall = res_valid_reg && res_stall;
    assign accept    = cmd_valid && !cmd_stall;
    assign op        = kind_t'(kind);
    assign full      = (fill_reg == CNT_W'(DEPTH));
    assign empty     = (fill_reg == '0);

    // Decide the operation, move at most one pointer and issue the single storage
    // access. An insert writes at the edge that accepts it and a later
    // remove reads no earlier than the next cycle, so no forwarding is needed.
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        status_next     = STATUS_DONE;
        pop_ok_next     = 1'b0;
        ram_req.wr_en   = 1'b0;
        ram_req.rd_en   = 1'b0;
        ram_req.addr    = head_reg;
        ram_req.wr_data = value;
        if (accept)
        begin
            unique case (op)
                KIND_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        head_next     = ptr_dec(head_reg);
                        ram_req.wr_en = 1'b1;
                        ram_req.addr  = ptr_dec(head_reg);
                        fill_next     = fill_reg + CNT_W'(1);
                    end
                end
                KIND_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        tail_next     = ptr_inc(tail_reg);
                        ram_req.wr_en = 1'b1;
                        ram_req.addr  = tail_reg;
                        fill_next     = fill_reg + CNT_W'(1);
                    end
                end
                KIND_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        head_next     = ptr_inc(head_reg);
                        ram_req.rd_en = 1'b1;
                        ram_req.addr  = head_reg;
                        pop_ok_next   = 1'b1;
                        fill_next     = fill_reg - CNT_W'(1);
                    end
                end
                KIND_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        tail_next     = ptr_dec(tail_reg);
                        ram_req.rd_en = 1'b1;
                        ram_req.addr  = ptr_dec(tail_reg);
                        pop_ok_next   = 1'b1;
                        fill_next     = fill_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = STATUS_DONE;
                end
            endcase
        end
    end

    // The result stage fills on every accepted command and empties when the
    // downstream side takes the transaction.
    always_comb
    begin
        if (accept)
            res_valid_next = 1'b1;
        else if (res_stall)
            res_valid_next = res_valid_reg;
        else
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload loads only on accept, which cannot happen while a
    // result is stalled, so the offered transaction stays steady.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= status_next;
            pop_ok_reg   <= pop_ok_next;
            fill_out_reg <= fill_next;
        end
    end

    // The storage read register is enabled only by an accepted remove, so it
    // also holds still while the result waits.
    deq_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    always_comb
    begin
        if (pop_ok_reg)
            value_res = rd_data;
        else if (status_reg == STATUS_EMPTY)
            value_res = EMPTY_WORD;
        else
            value_res = '0;
    end

    assign res_valid = res_valid_reg;
    assign status    = status_reg;
    assign count     = COUNT_W'(fill_out_reg);

    // The fill level never passes the capacity.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill level exceeds queue capacity");

    // Head and tail meet exactly when the queue is empty or full.
    a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
        ((fill_reg == '0) || (fill_reg == CNT_W'(DEPTH))) == (head_reg == tail_reg))
        else $error("pointers disagree with fill level");

    // An insert into a full queue is reported and leaves the state alone.
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && full && ((op == KIND_PUSH_FRONT) || (op == KIND_PUSH_BACK)))
        |=> (res_valid && (status_reg == STATUS_FULL) && $stable(fill_reg)
             && $stable(head_reg) && $stable(tail_reg)))
        else $error("insert into full queue was not dropped");

    // A remove from an empty queue reports an empty queue and the marker word.
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (status_reg == STATUS_EMPTY))
        |-> ((fill_out_reg == '0) && (value_res == EMPTY_WORD) && !pop_ok_reg))
        else $error("empty remove result is inconsistent");

    // The single storage port never reads and writes in one cycle.
    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_req.wr_en && ram_req.rd_en))
        else $error("storage read and write issued together");

endmodule

[sim/double_ended_queue_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the queue core. Every accepted command updates a
// private copy of the ring and queues the result it must produce. Every
// accepted result is compared with the oldest queued one.
module double_ended_queue_checker
    import deq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    input  logic                      cmd_stall,
    input  logic [1:0]                kind,
    input  logic signed [DATA_W-1:0]  value,
    input  logic                      res_valid,
    input  logic                      res_stall,
    input  logic signed [DATA_W-1:0]  value_res,
    input  logic [1:0]                status,
    input  logic [COUNT_W-1:0]        count,
    output int                        mismatch_count,
    output int                        pending
);

    typedef struct packed {
        logic signed [DATA_W-1:0] word;
        status_t                  code;
        logic [COUNT_W-1:0]       level;
    } deque_result_t;

    logic signed [DATA_W-1:0] ring_words [DEPTH];
    int                       front_idx;
    int                       back_idx;
    int                       fill_level;
    int                       result_number;
    int                       errors;
    deque_result_t            expected_results [$];

    assign mismatch_count = errors;
    assign pending        = expected_results.size();

    // Applies one operation to the private ring and returns what the core
    // must report for it.
    function automatic deque_result_t apply_operation(input kind_t op,
                                                      input logic signed [DATA_W-1:0] word);
        deque_result_t r;
        r.word = '0;
        r.code = STATUS_DONE;
        case (op)
            KIND_PUSH_FRONT, KIND_PUSH_BACK:
                if (fill_level >= DEPTH)
                    r.code = STATUS_FULL;
                else
                begin
                    if (op == KIND_PUSH_FRONT)
                    begin
                        front_idx = (front_idx + DEPTH - 1) % DEPTH;
                        ring_words[front_idx] = word;
                    end
                    else
                    begin
                        ring_words[back_idx] = word;
                        back_idx = (back_idx + 1) % DEPTH;
                    end
                    fill_level++;
                end
            KIND_POP_FRONT, KIND_POP_BACK:
                if (fill_level == 0)
                begin
                    r.word = -1;
                    r.code = STATUS_EMPTY;
                end
                else
                begin
                    if (op == KIND_POP_FRONT)
                    begin
                        r.word = ring_words[front_idx];
                        front_idx = (front_idx + 1) % DEPTH;
                    end
                    else
                    begin
                        back_idx = (back_idx + DEPTH - 1) % DEPTH;
                        r.word = ring_words[back_idx];
                    end
                    fill_level--;
                end
        endcase
        r.level = COUNT_W'(fill_level);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        deque_result_t want;
        if (!rst_n)
        begin
            front_idx     = 0;
            back_idx      = 0;
            fill_level    = 0;
            result_number = 0;
            errors        = 0;
            expected_results.delete();
        end
        else
        begin
            // A result always trails its command, so the
            // result side is settled before this edge's command is added.
            if (res_valid && !res_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("result %0d: unexpected, value_res=%0d status=%0d count=%0d",
                                 result_number, value_res, status, count);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (value_res !== want.word || status !== want.code
                        || count !== want.level)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"result %0d: expected value_res=%0d status=%0d ",
                                      "count=%0d, got value_res=%0d status=%0d count=%0d"},
                                     result_number, want.word, want.code, want.level,
                                     value_res, status, count);
                    end
                end
                result_number++;
            end
            if (cmd_valid && !cmd_stall)
                expected_results.push_back(apply_operation(kind_t'(kind), value));
        end
    end

endmodule

[sim/tb_double_ended_queue_core.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the double-ended queue core. The checker instance
// beside the core does all prediction and comparison; this module only
// generates command transactions, randomizes result stalls and decides the
// outcome once every expected result has come back.
module tb_double_ended_queue_core;
    import deq_pkg::*;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cmd_valid = 1'b0;
    logic                      cmd_stall;
    logic [1:0]                kind      = KIND_PUSH_FRONT;
    logic signed [DATA_W-1:0]  value     = '0;
    logic                      res_valid;
    logic                      res_stall = 1'b0;
    logic signed [DATA_W-1:0]  value_res;
    logic [1:0]                status;
    logic [COUNT_W-1:0]        count;

    int mismatch_count;
    int pending;

    // Percent chance per cycle that the command side idles and that the
    // result side stalls. These change from phase to phase.
    int idle_pct  = 0;
    int stall_pct = 0;

    // Words whose bits sit at the edges of the signed range. The last one
    // equals the empty marker, so a successful remove of it must still
    // report a done status.
    logic signed [DATA_W-1:0] corner_words [4] = '{32'sh7FFF_FFFF, 32'sh8000_0000,
                                                   32'sh0000_0000, 32'sh FFFF_FFFF};

    double_ended_queue_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .kind      (kind),
        .value     (value),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .value_res (value_res),
        .status    (status),
        .count     (count)
    );

    double_ended_queue_checker CHECK (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .kind           (kind),
        .value          (value),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .value_res      (value_res),
        .status         (status),
        .count          (count),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // The result side stalls on its own random schedule, independent of
    // anything the core offers.
    always @(posedge clk)
        res_stall <= ($urandom_range(99) < stall_pct);

    // Presents one command transaction and returns at the edge where it was
    // accepted. Random idle cycles go in front of it. The caller drives the
    // next transaction in that same time step, so valid is never dropped and
    // raised again within one step.
    task automatic send_command(input kind_t op, input logic signed [DATA_W-1:0] word);
        while ($urandom_range(99) < idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        kind      <= op;
        value     <= word;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    // Random traffic in short runs, each with its own leaning toward inserts
    // or removes. Runs that lean hard one way drive the queue into its full
    // and empty corners often; balanced runs keep it wandering in between,
    // so the pointers wrap in both directions.
    task automatic random_traffic(input int n_items);
        int    insert_pct;
        int    run_left;
        kind_t op;
        run_left   = 0;
        insert_pct = 50;
        for (int i = 0; i < n_items; i++)
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(40, 8);
                case ($urandom_range(2))
                    0:       insert_pct = 80;
                    1:       insert_pct = 20;
                    default: insert_pct = 50;
                endcase
            end
            run_left--;
            if ($urandom_range(99) < insert_pct)
                op = ($urandom_range(1) != 0) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
            else
                op = ($urandom_range(1) != 0) ? KIND_POP_BACK : KIND_POP_FRONT;
            // Mostly random words, with the occasional corner value.
            if ($urandom_range(15) == 0)
                send_command(op, corner_words[$urandom_range(3)]);
            else
                send_command(op, $urandom());
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening with no idling: removes from the empty queue at
        // both ends, a fill to capacity alternating ends with corner words
        // first, inserts at both ends into the full queue, then removes and
        // an insert that move the pointers across the wrap point.
        send_command(KIND_POP_FRONT, 32'sh1234_5678);
        send_command(KIND_POP_BACK, 32'sh1234_5678);
        for (int i = 0; i < DEPTH; i++)
            send_command(i[0] ? KIND_PUSH_BACK : KIND_PUSH_FRONT,
                         (i < 4) ? corner_words[i] : $urandom());
        send_command(KIND_PUSH_FRONT, 32'sh5555_5555);
        send_command(KIND_PUSH_BACK, 32'shAAAA_AAAA);
        send_command(KIND_POP_FRONT, '0);
        send_command(KIND_POP_BACK, '0);
        send_command(KIND_PUSH_BACK, 32'shAAAA_AAAA);
        send_command(KIND_POP_BACK, '1);

        // Random traffic under each idling pattern in turn.
        random_traffic(262);
        idle_pct = 46;
        random_traffic(262);
        idle_pct  = 0;
        stall_pct = 46;
        random_traffic(262);
        idle_pct  = 13;
        stall_pct = 13;
        random_traffic(264);
        cmd_valid <= 1'b0;

        // The checker records the last command at the edge where it was
        // accepted, so its count is only read from the following edge on.
        @(posedge clk);

        // Drain: wait for every expected result, then wait on so
        // that a stray extra result would still be caught.
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (mismatch_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hard limit, far beyond the slowest correct run of this traffic.
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
